// ===== sv/cdcc_pkg.sv =====
// Package: shared constants, types and the color palette for the clap detector.
`default_nettype none

package cdcc_pkg;

   // Arithmetic shift applied to each sample before taking its magnitude
   localparam int unsigned SAMPLE_SHIFT = 11;
   // Number of colors stepped through on a single clap (1 to 8)
   localparam int unsigned COLOR_COUNT  = 6;

   localparam int unsigned AMP_W   = 21;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned LEVEL_W = 7;
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 21;

   localparam logic [AMP_W-1:0] AMP_MAX = 21'd1048576;
   localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

   // Register reset values
   localparam logic [AMP_W-1:0] AMP_THR_RESET    = 21'd90000;
   localparam logic [AMP_W-1:0] JUMP_THR_RESET   = 21'd90000;
   localparam logic [MS_W-1:0]  REFRACTORY_RESET = 16'd250;
   localparam logic [MS_W-1:0]  WINDOW_RESET     = 16'd400;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_THR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW     = 2'd3;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } color_type;

   // Color table; entries past the six defined colors are black
   function automatic color_type palette(input logic [IDX_W-1:0] idx);
      color_type c;
      case (idx)
         3'd0:    c = '{7'd100, 7'd0,   7'd0};
         3'd1:    c = '{7'd0,   7'd100, 7'd0};
         3'd2:    c = '{7'd0,   7'd0,   7'd100};
         3'd3:    c = '{7'd127, 7'd0,   7'd127};
         3'd4:    c = '{7'd127, 7'd127, 7'd127};
         3'd5:    c = '{7'd0,   7'd127, 7'd127};
         default: c = '{7'd0,   7'd0,   7'd0};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/cdcc_if.sv =====
// Interfaces: sample input channel and result channel of the clap detector.
`default_nettype none

interface cdcc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;
   logic        block_end;
   logic [31:0] time_ms;

   modport source (output valid, output sample, output block_end, output time_ms,
                   input ready);
   modport sink   (input valid, input sample, input block_end, input time_ms,
                   output ready);
endinterface

interface cdcc_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_update;
   logic [6:0]  red;
   logic [6:0]  green;
   logic [6:0]  blue;
   logic        clap_seen;
   logic [20:0] block_amplitude;

   modport source (output valid, output drive_update, output red, output green,
                   output blue, output clap_seen, output block_amplitude,
                   input ready);
   modport sink   (input valid, input drive_update, input red, input green,
                   input blue, input clap_seen, input block_amplitude,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/clap_detect_color_cycler.sv =====
// Top level: clap detector that steps an LED color on one clap and blanks it on two.
`default_nettype none

// Takes one microphone sample per transaction and returns one result transaction
// for each sample marked as a block end, none for other samples. A sample enters
// an input register that holds its scaled magnitude; the peak, clap and color logic
// then runs against the held state and loads the result register. A new sample is
// accepted every cycle unless a block-end sample waits in the input register: only
// a block-end sample waits, when the result register is still full, since it alone
// writes it. The user must make configuration writes only while idle; the block
// itself does not enforce this.
module clap_detect_color_cycler
   import cdcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   cdcc_req_if.sink                   req_bus,
   cdcc_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers
   logic [AMP_W-1:0] amp_thr_ff;
   logic [AMP_W-1:0] jump_thr_ff;
   logic [MS_W-1:0]  refractory_ff;
   logic [MS_W-1:0]  window_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_thr_ff    <= AMP_THR_RESET;
         jump_thr_ff   <= JUMP_THR_RESET;
         refractory_ff <= REFRACTORY_RESET;
         window_ms_ff  <= WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AMP_THR:    amp_thr_ff    <= csr_data;
            CSR_JUMP_THR:   jump_thr_ff   <= csr_data;
            CSR_REFRACTORY: refractory_ff <= csr_data[MS_W-1:0];
            CSR_WINDOW:     window_ms_ff  <= csr_data[MS_W-1:0];
            default: ;
         endcase
      end
   end

   // Scaled magnitude of the incoming sample, saturated
   logic [31:0]      samp_u;
   logic [32:0]      mag_wide;
   logic [AMP_W-1:0] mag_in;

   always_comb begin
      samp_u = req_bus.sample;
      if (samp_u[31]) begin
         mag_wide = {1'b0, (~samp_u) >> SAMPLE_SHIFT} + 33'd1;
      end else begin
         mag_wide = {1'b0, samp_u >> SAMPLE_SHIFT};
      end
      if (mag_wide > {12'd0, AMP_MAX}) begin
         mag_in = AMP_MAX;
      end else begin
         mag_in = mag_wide[AMP_W-1:0];
      end
   end

   // Input register stage
   logic              s1_valid_ff;
   logic [AMP_W-1:0]  s1_mag_ff;
   logic              s1_end_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic              out_valid_ff;
   logic              advance;
   logic              req_take;

   assign advance  = s1_valid_ff && (!s1_end_ff || !out_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mag_ff  <= mag_in;
         s1_end_ff  <= req_bus.block_end;
         s1_time_ff <= req_bus.time_ms;
      end
   end

   // Detector state
   logic [AMP_W-1:0]  peak_ff;
   logic [AMP_W-1:0]  prev_amp_ff;
   logic [TIME_W-1:0] last_clap_ff;
   logic [CNT_W-1:0]  clap_cnt_ff;
   logic [IDX_W-1:0]  color_idx_ff;

   logic [AMP_W-1:0]  amp_in;
   logic [AMP_W-1:0]  delta;
   logic [TIME_W-1:0] elapsed;
   logic              clap;
   logic              fire;
   logic [CNT_W-1:0]  clap_cnt_in;
   logic [IDX_W:0]    idx_inc;
   logic [IDX_W-1:0]  idx_step;
   logic [IDX_W-1:0]  color_idx_in;
   logic              drive;
   color_type         color;

   // Peak, clap test and pending-count action
   always_comb begin
      amp_in  = (s1_mag_ff > peak_ff) ? s1_mag_ff : peak_ff;
      delta   = (amp_in > prev_amp_ff) ? amp_in - prev_amp_ff : prev_amp_ff - amp_in;
      elapsed = s1_time_ff - last_clap_ff;
      clap    = (amp_in > amp_thr_ff) && (delta > jump_thr_ff)
                && (elapsed > {16'd0, refractory_ff});
      // a fresh clap resets elapsed time to zero, so the window cannot expire
      fire    = !clap && (clap_cnt_ff != '0) && (elapsed > {16'd0, window_ms_ff});

      clap_cnt_in = clap_cnt_ff;
      if (clap) begin
         if (clap_cnt_ff != CNT_MAX) begin
            clap_cnt_in = clap_cnt_ff + 3'd1;
         end
      end else if (fire) begin
         clap_cnt_in = '0;
      end

      idx_inc  = {1'b0, color_idx_ff} + 4'd1;
      idx_step = (idx_inc == 4'(COLOR_COUNT)) ? '0 : idx_inc[IDX_W-1:0];

      color_idx_in = color_idx_ff;
      drive        = 1'b0;
      color        = '0;
      if (fire && clap_cnt_ff == 3'd1) begin
         color_idx_in = idx_step;
         drive        = 1'b1;
         color        = palette(idx_step);
      end else if (fire && clap_cnt_ff == 3'd2) begin
         drive        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         prev_amp_ff  <= '0;
         last_clap_ff <= '0;
         clap_cnt_ff  <= '0;
         color_idx_ff <= '0;
      end else if (advance) begin
         if (s1_end_ff) begin
            peak_ff      <= '0;
            prev_amp_ff  <= amp_in;
            clap_cnt_ff  <= clap_cnt_in;
            color_idx_ff <= color_idx_in;
            if (clap) begin
               last_clap_ff <= s1_time_ff;
            end
         end else begin
            peak_ff <= amp_in;
         end
      end
   end

   // Result register
   logic             drive_ff;
   color_type        color_ff;
   logic             clap_seen_ff;
   logic [AMP_W-1:0] amp_out_ff;
   logic             out_load;

   assign out_load = advance && s1_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         drive_ff     <= drive;
         color_ff     <= color;
         clap_seen_ff <= clap;
         amp_out_ff   <= amp_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.drive_update    = drive_ff;
   assign rsp_bus.red             = color_ff.red;
   assign rsp_bus.green           = color_ff.green;
   assign rsp_bus.blue            = color_ff.blue;
   assign rsp_bus.clap_seen       = clap_seen_ff;
   assign rsp_bus.block_amplitude = amp_out_ff;

   // Checks
   a_color_idx_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, color_idx_ff} < 4'(COLOR_COUNT))
      else $error("color index out of range");

   a_dark_when_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !drive_ff) |-> (color_ff == '0))
      else $error("color levels set without a color update");

   a_clap_excludes_drive: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && clap_seen_ff) |-> !drive_ff)
      else $error("color driven in the block that counted a clap");

   a_clap_above_thr: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && clap_seen_ff) |-> (amp_out_ff > amp_thr_ff))
      else $error("clap counted below amplitude threshold");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready && s1_valid_ff && s1_end_ff)
      |=> $stable(prev_amp_ff) && $stable(clap_cnt_ff))
      else $error("block end processed while result register was full");

endmodule

`default_nettype wire

// ===== tb/sv/tb_clap_detect_color_cycler.sv =====
// Clap detector testbench: directed and random samples checked against a cycle-free predictor.
module tb_clap_detect_color_cycler;
   import cdcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 120;

   // One microphone sample transaction
   typedef struct packed {
      logic [31:0] sample;
      logic        block_end;
      logic [31:0] time_ms;
   } mic_item_type;

   // One block result transaction
   typedef struct packed {
      logic               drive_update;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic               clap_seen;
      logic [AMP_W-1:0]   block_amplitude;
   } led_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cdcc_req_if req_bus ();
   cdcc_rsp_if rsp_bus ();

   clap_detect_color_cycler dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   mic_item_type   sample_queue [$];
   led_result_type expected_leds [$];

   // Predictor copy of the registers
   logic [AMP_W-1:0] amp_thr    = AMP_THR_RESET;
   logic [AMP_W-1:0] jump_thr   = JUMP_THR_RESET;
   logic [MS_W-1:0]  refractory = REFRACTORY_RESET;
   logic [MS_W-1:0]  window     = WINDOW_RESET;

   // Predictor copy of the block state
   logic [AMP_W-1:0]  running_peak = '0;
   logic [AMP_W-1:0]  prev_amp     = '0;
   logic [TIME_W-1:0] last_clap_ms = '0;
   logic [CNT_W-1:0]  pending_claps = '0;
   logic [IDX_W-1:0]  color_idx    = '0;
   color_type         led_colors [0:7];

   // Traffic control and bookkeeping
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   logic        hold_request = 1'b0;
   int          hold_left    = 0;
   logic        req_taken    = 1'b0;
   logic        rsp_taken    = 1'b0;
   int          idle_cycles  = 0;
   int          mismatches   = 0;
   int          phase_count  = 0;
   logic [31:0] now_ms       = '0;

   // |sample >>> SAMPLE_SHIFT|, clipped to the amplitude range
   function automatic logic [AMP_W-1:0] scaled_mag(input logic [31:0] s);
      logic [32:0] m;
      if (s[31])
         m = ({1'b0, ~s} >> SAMPLE_SHIFT) + 33'd1;
      else
         m = {1'b0, s} >> SAMPLE_SHIFT;
      if (m > 33'(AMP_MAX))
         m = 33'(AMP_MAX);
      return m[AMP_W-1:0];
   endfunction

   // Advance the predictor by one accepted sample; queue a result on block end
   function automatic void step_clap_model(input logic [31:0] s, input logic be,
                                           input logic [31:0] now);
      logic [AMP_W-1:0]  mag;
      logic [AMP_W-1:0]  amp;
      logic [AMP_W-1:0]  diff;
      logic [TIME_W-1:0] since;
      led_result_type    r;
      mag = scaled_mag(s);
      if (mag > running_peak)
         running_peak = mag;
      if (be) begin
         amp = running_peak;
         running_peak = '0;
         diff = (amp > prev_amp) ? amp - prev_amp : prev_amp - amp;
         r = '0;
         r.block_amplitude = amp;
         since = now - last_clap_ms;
         if (amp > amp_thr && diff > jump_thr && since > {16'b0, refractory}) begin
            r.clap_seen = 1'b1;
            if (pending_claps != CNT_MAX)
               pending_claps = pending_claps + 3'd1;
            last_clap_ms = now;
         end
         prev_amp = amp;
         since = now - last_clap_ms;
         // window expired: act on the pending count, then clear it
         if (pending_claps != 0 && since > {16'b0, window}) begin
            if (pending_claps == 3'd1) begin
               color_idx = IDX_W'((int'(color_idx) + 1) % COLOR_COUNT);
               {r.red, r.green, r.blue} = led_colors[color_idx];
               r.drive_update = 1'b1;
            end else if (pending_claps == 3'd2) begin
               r.drive_update = 1'b1;
            end
            pending_claps = '0;
         end
         expected_leds.push_back(r);
      end
   endfunction

   // Sample driver: next transaction at the falling edge
   always @(negedge clock) begin : driver
      mic_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (sample_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            item = sample_queue.pop_front();
            req_bus.sample    <= item.sample;
            req_bus.block_end <= item.block_end;
            req_bus.time_ms   <= item.time_ms;
            req_bus.valid     <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Monitor: check results, feed the predictor, run the watchdog
   always @(posedge clock) begin : monitor
      led_result_type got;
      led_result_type want;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         rsp_taken = rsp_bus.valid && rsp_bus.ready;
         if (rsp_taken) begin
            got = {rsp_bus.drive_update, rsp_bus.red, rsp_bus.green, rsp_bus.blue,
                   rsp_bus.clap_seen, rsp_bus.block_amplitude};
            if (expected_leds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result at %0t: upd=%0d rgb=%0d/%0d/%0d clap=%0d amp=%0d",
                           $realtime, got.drive_update, got.red, got.green, got.blue,
                           got.clap_seen, got.block_amplitude);
            end else begin
               want = expected_leds.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch at %0t: expected upd=%0d rgb=%0d/%0d/%0d clap=%0d",
                               " amp=%0d, got upd=%0d rgb=%0d/%0d/%0d clap=%0d amp=%0d"},
                              $realtime, want.drive_update, want.red, want.green,
                              want.blue, want.clap_seen, want.block_amplitude,
                              got.drive_update, got.red, got.green, got.blue,
                              got.clap_seen, got.block_amplitude);
               end
            end
         end
         if (req_taken)
            step_clap_model(req_bus.sample, req_bus.block_end, req_bus.time_ms);
         if (req_taken || rsp_taken)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Register write while the block is idle; predictor copy follows
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AMP_THR:    amp_thr    = data;
         CSR_JUMP_THR:   jump_thr   = data;
         CSR_REFRACTORY: refractory = data[MS_W-1:0];
         CSR_WINDOW:     window     = data[MS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned a, input int unsigned j,
                            input int unsigned r, input int unsigned w);
      write_reg(CSR_AMP_THR, CSR_DATA_W'(a));
      write_reg(CSR_JUMP_THR, CSR_DATA_W'(j));
      write_reg(CSR_REFRACTORY, CSR_DATA_W'(r));
      write_reg(CSR_WINDOW, CSR_DATA_W'(w));
      @(posedge clock);
   endtask

   // Drain everything, then let in-flight non-block-end samples retire
   task automatic finish_phase();
      while (sample_queue.size() != 0 || req_bus.valid || expected_leds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sample whose scaled magnitude is about mag, random sign and low bits
   function automatic logic [31:0] sample_at(input int unsigned mag);
      logic [31:0] s;
      if (mag >= 32'(AMP_MAX))
         return 32'h8000_0000;
      s = 32'(mag << SAMPLE_SHIFT) | 32'($urandom_range(0, 2047));
      if ($urandom_range(0, 1) != 0)
         s = -s;
      return s;
   endfunction

   function automatic int unsigned quiet_level();
      int unsigned a;
      a = 32'(amp_thr);
      return $urandom_range(0, a / 4);
   endfunction

   // Peak that clears both thresholds against a quiet previous block
   function automatic int unsigned loud_level();
      int unsigned a;
      int unsigned j;
      int unsigned lo;
      a = 32'(amp_thr);
      j = 32'(jump_thr);
      lo = a;
      if (j + a / 4 + 1 > lo)
         lo = j + a / 4 + 1;
      lo = lo + 1 + $urandom_range(0, 4000);
      return (lo > 32'(AMP_MAX)) ? 32'(AMP_MAX) : lo;
   endfunction

   task automatic push_sample(input logic [31:0] s, input logic be, input int unsigned adv);
      mic_item_type it;
      now_ms += adv;
      it.sample    = s;
      it.block_end = be;
      it.time_ms   = now_ms;
      sample_queue.push_back(it);
      phase_count++;
   endtask

   task automatic push_at(input logic [31:0] s, input logic be, input logic [31:0] t);
      now_ms = t;
      push_sample(s, be, 0);
   endtask

   // One amplitude block of 1 to 3 samples with the given peak
   task automatic push_block(input int unsigned peak, input int unsigned adv);
      int n;
      int hit;
      n = $urandom_range(1, 3);
      hit = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++)
         push_sample(sample_at(i == hit ? peak : $urandom_range(0, peak)), i == n - 1,
                     i == 0 ? adv : $urandom_range(0, 3));
   endtask

   // A run of claps spaced past the refractory time, optionally left to expire
   task automatic push_burst(input int claps, input logic settle);
      int unsigned refr;
      int unsigned win;
      refr = 32'(refractory);
      win = 32'(window);
      for (int c = 0; c < claps; c++) begin
         push_block(quiet_level(), $urandom_range(1, 20));
         push_block(loud_level(), refr + 1 + $urandom_range(0, 40));
      end
      if (settle)
         push_block(quiet_level(), win + 1 + $urandom_range(0, 40));
   endtask

   task automatic push_scene();
      int          roll;
      int          claps;
      int unsigned refr;
      int unsigned win;
      refr = 32'(refractory);
      win = 32'(window);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         roll = $urandom_range(0, 99);
         claps = (roll < 40) ? 1 : (roll < 70) ? 2 : (roll < 85) ? 3 : $urandom_range(4, 9);
         push_burst(claps, $urandom_range(0, 4) != 0);
      end else if (roll < 75) begin
         // raw noise, occasionally with huge time jumps
         repeat ($urandom_range(1, 6))
            push_sample($urandom, $urandom_range(0, 2) == 0,
                        ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 600));
      end else if (roll < 90) begin
         // rejected claps: too soon after the last one, or no jump
         push_block(loud_level(), refr + 1 + $urandom_range(0, 40));
         if ($urandom_range(0, 1) != 0) begin
            push_block(loud_level(), $urandom_range(0, refr));
         end else begin
            push_block(quiet_level(), 0);
            push_block(loud_level(), $urandom_range(0, refr));
         end
      end else begin
         repeat ($urandom_range(1, 4))
            push_block(quiet_level(), $urandom_range(0, 2 * win + 2));
      end
   endtask

   task automatic run_random(input int target);
      phase_count = 0;
      while (phase_count < target)
         push_scene();
   endtask

   initial begin : stimulus
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      req_bus.block_end = 1'b0;
      req_bus.time_ms = '0;
      rsp_bus.ready = 1'b0;

      led_colors[0] = '{7'd100, 7'd0,   7'd0};
      led_colors[1] = '{7'd0,   7'd100, 7'd0};
      led_colors[2] = '{7'd0,   7'd0,   7'd100};
      led_colors[3] = '{7'd127, 7'd0,   7'd127};
      led_colors[4] = '{7'd127, 7'd127, 7'd127};
      led_colors[5] = '{7'd0,   7'd127, 7'd127};
      led_colors[6] = '{7'd0,   7'd0,   7'd0};
      led_colors[7] = '{7'd0,   7'd0,   7'd0};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, no idling: directed corners first
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      push_at(32'h0000_0000, 1'b0, 32'd10);
      push_at(32'h7FFF_FFFF, 1'b0, 32'd20);
      push_at(32'hFFFF_FFFF, 1'b1, 32'd30);     // loud but inside refractory from time 0
      push_at(32'h8000_0000, 1'b1, 32'd300);    // full-scale negative, no jump
      push_at(32'h0000_0000, 1'b1, 32'd310);    // big drop, amplitude too low
      push_at(32'h8000_0000, 1'b1, 32'd600);    // clap
      push_at(32'h0000_07FF, 1'b1, 32'd700);    // still inside window
      push_at(32'h0000_0000, 1'b1, 32'd1001);   // one clap: next color
      push_at(32'h7FFF_FFFF, 1'b1, 32'd1300);
      push_at(32'h0000_0000, 1'b1, 32'd1400);
      push_at(32'h8000_0000, 1'b1, 32'd1600);
      push_at(32'h0000_0000, 1'b1, 32'd2100);   // two claps: black
      push_at(32'h7FFF_FFFF, 1'b1, 32'd2400);
      push_at(32'h0000_0000, 1'b1, 32'd2450);
      push_at(32'h8000_0000, 1'b1, 32'd2700);
      push_at(32'h0000_0000, 1'b1, 32'd2750);
      push_at(32'h7FFF_FFFF, 1'b1, 32'd3000);
      push_at(32'h0000_0000, 1'b1, 32'd3500);   // three claps: nothing driven
      push_at(32'h8000_0000, 1'b1, 32'd4000);
      push_at(32'h0000_0000, 1'b1, 32'd4050);
      push_at(32'h7FFF_FFFF, 1'b1, 32'd4200);   // within refractory: not counted
      push_at(32'h0000_0000, 1'b1, 32'd4700);
      push_at(32'h8000_0000, 1'b1, 32'hFFFF_FF00);
      push_at(32'h0000_0000, 1'b1, 32'h0000_0100); // elapsed time across the wrap
      run_random(60);
      finish_phase();

      // All registers at zero, sender idling
      configure(0, 0, 0, 0);
      sender_idle_pct = 58;
      run_random(70);
      finish_phase();

      // All registers at their maximum, receiver stalling
      configure(32'(AMP_MAX), 32'(AMP_MAX), 32'hFFFF, 32'hFFFF);
      sender_idle_pct = 0;
      receiver_stall_pct = 58;
      now_ms = $urandom;
      run_random(60);
      finish_phase();

      // Low thresholds with the longest window: clap count saturation
      configure(1000, 500, 0, 32'hFFFF);
      sender_idle_pct = 13;
      receiver_stall_pct = 13;
      phase_count = 0;
      push_burst(9, 1'b1);
      run_random(70);
      finish_phase();

      // Long receiver hold-off while samples keep coming
      configure($urandom_range(0, 300000), $urandom_range(0, 300000),
                $urandom_range(0, 600), $urandom_range(0, 1500));
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      now_ms = $urandom;
      run_random(80);
      hold_request = 1'b1;
      finish_phase();

      // Random settings, both sides idling
      configure($urandom_range(0, 300000), $urandom_range(0, 300000),
                $urandom_range(0, 600), $urandom_range(0, 1500));
      sender_idle_pct = 13;
      receiver_stall_pct = 13;
      run_random(70);
      finish_phase();

      if (mismatches == 0 && expected_leds.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== clap_detect_color_cycler.f =====
sv/cdcc_pkg.sv
sv/cdcc_if.sv
sv/clap_detect_color_cycler.sv
tb/sv/tb_clap_detect_color_cycler.sv
